// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the windowed PID block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define WPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("windowed PID assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define WPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("windowed PID assertion failed");

// Next-cycle implication that also holds through reset.
`define WPID_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("windowed PID assertion failed");

`endif

// File: design/wpid_pkg.sv
// ----------------------------------------------------------------------------
// wpid_pkg
// Widths, reset values, register indexes and shared types of the windowed
// PID controller.
// ----------------------------------------------------------------------------
package wpid_pkg;

    localparam int MEAS_W   = 16;
    localparam int SETPT_W  = 16;
    localparam int GAIN_W   = 20;
    localparam int ERR_W    = 18;
    localparam int SUM_W    = 23;
    localparam int DIFF_W   = 19;
    localparam int DRIVE_W  = 32;
    localparam int FRAC_W   = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 20;

    // Signed gain operand is the unsigned gain with a zero on top.
    localparam int GAIN_S_W = GAIN_W + 1;
    localparam int PROD_P_W = GAIN_S_W + ERR_W;
    localparam int PROD_I_W = GAIN_S_W + SUM_W;
    localparam int PROD_D_W = GAIN_S_W + DIFF_W;
    localparam int ACC_W    = PROD_I_W + 2;

    localparam int DEFAULT_WINDOW = 10;

    localparam logic signed [SETPT_W-1:0] SETPT_RST  = 16'sd100;
    localparam logic [GAIN_W-1:0]         GAIN_P_RST = 20'd128000;
    localparam logic [GAIN_W-1:0]         GAIN_I_RST = 20'd20480;
    localparam logic [GAIN_W-1:0]         GAIN_D_RST = 20'd51200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 8'd0,
        CFG_GAIN_P   = 8'd1,
        CFG_GAIN_I   = 8'd2,
        CFG_GAIN_D   = 8'd3
    } t_cfg_idx;

    // Load enables for the product and sum stages of the datapath.
    typedef struct packed {
        logic prod;
        logic sum;
    } t_stage_en;

endpackage

// File: design/wpid_ifs.sv
// ----------------------------------------------------------------------------
// wpid channel interfaces
// Valid/ready channels for measurements, results and register writes.
// ----------------------------------------------------------------------------
interface wpid_meas_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [wpid_pkg::MEAS_W-1:0]       measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface wpid_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [wpid_pkg::DRIVE_W-1:0]      drive;
    logic                                     saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink   (input valid, input drive, input saturated, output ready);
endinterface

interface wpid_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic [wpid_pkg::CFG_IDX_W-1:0]           index;
    logic [wpid_pkg::CFG_DAT_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/windowed_pid_controller_unit.sv
// Each result is registered in stage A, the product stage and the output stage in turn.
// Throughput: one measurement per cycle, limited only by the result side.
// The three gain products are registered before they are summed and clipped.
// Reset clears the error history, the window sum and the pipeline, and puts
// the setpoint and gains back to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// windowed_pid_controller_unit
// PID controller whose integral term is the sum of the last WINDOW errors.
// ----------------------------------------------------------------------------
module windowed_pid_controller_unit #(
    parameter int WINDOW = wpid_pkg::DEFAULT_WINDOW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wpid_meas_if.sink            i_meas,
    wpid_cfg_if.sink             i_cfg,
    wpid_result_if.source        o_result
);

    localparam int ERR_W  = wpid_pkg::ERR_W;
    localparam int SUM_W  = wpid_pkg::SUM_W;
    localparam int DIFF_W = wpid_pkg::DIFF_W;

    // Configuration registers. Writes are to arrive only while the block is idle;
    // the block itself does not enforce this, and its cfg ready is tied high.
    logic signed [wpid_pkg::SETPT_W-1:0] r_setpoint;
    logic [wpid_pkg::GAIN_W-1:0]         r_gain_p;
    logic [wpid_pkg::GAIN_W-1:0]         r_gain_i;
    logic [wpid_pkg::GAIN_W-1:0]         r_gain_d;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= wpid_pkg::SETPT_RST;
            r_gain_p   <= wpid_pkg::GAIN_P_RST;
            r_gain_i   <= wpid_pkg::GAIN_I_RST;
            r_gain_d   <= wpid_pkg::GAIN_D_RST;
        end else if (i_cfg.valid) begin
            unique case (wpid_pkg::t_cfg_idx'(i_cfg.index))
                wpid_pkg::CFG_SETPOINT: begin
                    r_setpoint <= i_cfg.data[wpid_pkg::SETPT_W-1:0];
                end
                wpid_pkg::CFG_GAIN_P: begin
                    r_gain_p <= i_cfg.data[wpid_pkg::GAIN_W-1:0];
                end
                wpid_pkg::CFG_GAIN_I: begin
                    r_gain_i <= i_cfg.data[wpid_pkg::GAIN_W-1:0];
                end
                wpid_pkg::CFG_GAIN_D: begin
                    r_gain_d <= i_cfg.data[wpid_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline control. Stage A holds the error terms, stage B the products
    // and stage C the output register. A stage may load when it is empty or
    // when the stage after it is moving, so a bubble anywhere lets the input
    // side keep accepting while a result waits at the output.
    logic r_valid_a;
    logic r_valid_b;
    logic r_valid_c;
    logic adv_c;
    logic can_b;
    logic can_a;
    logic accept;
    wpid_pkg::t_stage_en stage_en;

    assign adv_c  = !r_valid_c || o_result.ready;
    assign can_b  = !r_valid_b || adv_c;
    assign can_a  = !r_valid_a || can_b;
    assign accept = i_meas.valid && can_a;

    assign i_meas.ready   = can_a;
    assign o_result.valid = r_valid_c;

    assign stage_en.prod = can_b;
    assign stage_en.sum  = adv_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else begin
            if (can_a) begin
                r_valid_a <= i_meas.valid;
            end
            if (can_b) begin
                r_valid_b <= r_valid_a;
            end
            if (adv_c) begin
                r_valid_c <= r_valid_b;
            end
        end
    end

    // Error history as a shift line: entry 0 is the newest error and the
    // last entry is the oldest, which leaves the window when a new error
    // comes in. The running sum is kept in step with it.
    logic signed [ERR_W-1:0]  r_hist [WINDOW];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DIFF_W-1:0] n_diff;

    always_comb begin
        n_err  = ERR_W'(r_setpoint) - ERR_W'(i_meas.measurement);
        n_sum  = r_sum - SUM_W'(r_hist[WINDOW-1]) + SUM_W'(n_err);
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_hist[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_hist[k] <= '0;
            end
            r_sum <= '0;
        end else if (accept) begin
            r_hist[0] <= n_err;
            for (int k = 1; k < WINDOW; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            r_sum <= n_sum;
        end
    end

    // Stage A payload: the three multiplicands of this item.
    logic signed [ERR_W-1:0]  r_a_err;
    logic signed [SUM_W-1:0]  r_a_sum;
    logic signed [DIFF_W-1:0] r_a_diff;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_err  <= n_err;
            r_a_sum  <= n_sum;
            r_a_diff <= n_diff;
        end
    end

    wpid_mac u_mac (
        .i_clk       (i_clk),
        .i_en        (stage_en),
        .i_err       (r_a_err),
        .i_sum       (r_a_sum),
        .i_diff      (r_a_diff),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .o_drive     (o_result.drive),
        .o_saturated (o_result.saturated)
    );

endmodule

// File: design/wpid_mac.sv
// ----------------------------------------------------------------------------
// wpid_mac
// Three gain products in one stage, then their sum, the floor shift by the
// fraction width and the 32-bit saturation in the next.
// ----------------------------------------------------------------------------
module wpid_mac (
    input  logic                                    i_clk,
    input  wpid_pkg::t_stage_en                     i_en,
    input  logic signed [wpid_pkg::ERR_W-1:0]       i_err,
    input  logic signed [wpid_pkg::SUM_W-1:0]       i_sum,
    input  logic signed [wpid_pkg::DIFF_W-1:0]      i_diff,
    input  logic [wpid_pkg::GAIN_W-1:0]             i_gain_p,
    input  logic [wpid_pkg::GAIN_W-1:0]             i_gain_i,
    input  logic [wpid_pkg::GAIN_W-1:0]             i_gain_d,
    output logic signed [wpid_pkg::DRIVE_W-1:0]     o_drive,
    output logic                                    o_saturated
);

    localparam int ACC_W = wpid_pkg::ACC_W;
    localparam int DRV_W = wpid_pkg::DRIVE_W;

    logic signed [wpid_pkg::GAIN_S_W-1:0] gain_p_s;
    logic signed [wpid_pkg::GAIN_S_W-1:0] gain_i_s;
    logic signed [wpid_pkg::GAIN_S_W-1:0] gain_d_s;

    logic signed [wpid_pkg::PROD_P_W-1:0] r_prod_p;
    logic signed [wpid_pkg::PROD_I_W-1:0] r_prod_i;
    logic signed [wpid_pkg::PROD_D_W-1:0] r_prod_d;

    logic signed [ACC_W-1:0]              acc;
    logic signed [ACC_W-1:0]              shifted;
    logic                                 over_pos;
    logic                                 over_neg;
    logic signed [DRV_W-1:0]              n_drive;
    logic                                 n_saturated;
    logic signed [DRV_W-1:0]              r_drive;
    logic                                 r_saturated;

    assign gain_p_s = signed'({1'b0, i_gain_p});
    assign gain_i_s = signed'({1'b0, i_gain_i});
    assign gain_d_s = signed'({1'b0, i_gain_d});

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_prod_p <= wpid_pkg::PROD_P_W'(gain_p_s * i_err);
            r_prod_i <= wpid_pkg::PROD_I_W'(gain_i_s * i_sum);
            r_prod_d <= wpid_pkg::PROD_D_W'(gain_d_s * i_diff);
        end
    end

    // Arithmetic right shift of a two's complement value rounds toward
    // minus infinity, which is the required floor.
    always_comb begin
        acc      = ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
        shifted  = acc >>> wpid_pkg::FRAC_W;
        over_pos = !shifted[ACC_W-1] && (|shifted[ACC_W-2:DRV_W-1]);
        over_neg = shifted[ACC_W-1] && !(&shifted[ACC_W-2:DRV_W-1]);
        priority if (over_pos) begin
            n_drive = {1'b0, {(DRV_W-1){1'b1}}};
        end else if (over_neg) begin
            n_drive = {1'b1, {(DRV_W-1){1'b0}}};
        end else begin
            n_drive = shifted[DRV_W-1:0];
        end
        n_saturated = over_pos || over_neg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_drive     <= n_drive;
            r_saturated <= n_saturated;
        end
    end

    assign o_drive     = r_drive;
    assign o_saturated = r_saturated;

endmodule

// File: design/wpid_checker.sv
// ----------------------------------------------------------------------------
// wpid_checker
// Port-level checks on the windowed PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpid_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_meas_ready,
    input logic                                 i_res_valid,
    input logic                                 i_res_ready,
    input logic signed [wpid_pkg::DRIVE_W-1:0]  i_res_drive,
    input logic                                 i_res_saturated
);

    localparam logic signed [wpid_pkg::DRIVE_W-1:0] DRIVE_MAX =
        {1'b0, {(wpid_pkg::DRIVE_W-1){1'b1}}};
    localparam logic signed [wpid_pkg::DRIVE_W-1:0] DRIVE_MIN =
        {1'b1, {(wpid_pkg::DRIVE_W-1){1'b0}}};

    // A result held back by the sink keeps its value.
    `WPID_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_drive) && $stable(i_res_saturated))

    // A clipped result sits exactly at one end of the 32-bit range.
    `WPID_ASSERT_IMP(a_sat_rail, i_clk, i_rst_n, i_res_valid && i_res_saturated, (i_res_drive == DRIVE_MAX) || (i_res_drive == DRIVE_MIN))

    // With the output register empty the pipeline can always take a sample.
    `WPID_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !i_res_valid, i_meas_ready)

    // Reset empties the pipeline.
    `WPID_ASSERT_NXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_res_valid)

endmodule

bind windowed_pid_controller_unit wpid_checker u_wpid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_meas_ready    (i_meas.ready),
    .i_res_valid     (o_result.valid),
    .i_res_ready     (o_result.ready),
    .i_res_drive     (o_result.drive),
    .i_res_saturated (o_result.saturated)
);

// File: dv/windowed_pid_controller_unit_test.sv
// ----------------------------------------------------------------------------
// windowed_pid_controller_unit_test
// Self-checking bench for the windowed PID controller. A directed table covers
// reset values, ignored register writes, zero and full-scale gains, and
// clipping at both ends. Random phases with varied idling and stalls follow.
// Every result word is checked against a predictor in the bench or a typed table expectation.
// ----------------------------------------------------------------------------
module windowed_pid_controller_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEAS_W    = wpid_pkg::MEAS_W;
    localparam int SETPT_W   = wpid_pkg::SETPT_W;
    localparam int GAIN_W    = wpid_pkg::GAIN_W;
    localparam int ERR_W     = wpid_pkg::ERR_W;
    localparam int SUM_W     = wpid_pkg::SUM_W;
    localparam int DRIVE_W   = wpid_pkg::DRIVE_W;
    localparam int FRAC_W    = wpid_pkg::FRAC_W;
    localparam int CFG_IDX_W = wpid_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = wpid_pkg::CFG_DAT_W;

    localparam int WINDOW       = wpid_pkg::DEFAULT_WINDOW;
    localparam int RESET_CYCLES = 7;
    // The block registers the error terms, the products and the drive word in turn.
    localparam int PIPE_LATENCY = 2;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 212;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_ROWS     = 19;

    // Register indexes past the end of the list; the block ignores writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAST_END = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED   = 8'd200;

    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;
    localparam logic [GAIN_W-1:0] GAIN_FULL = 20'hFFFFF;

    // Percent chance of a sender gap and of a receiver stall, one pair per phase.
    localparam int SEND_IDLE_PCT [4] = '{0, 58, 0, 30};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 58, 30};

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } t_drive_word;

    typedef enum bit {
        ROW_MEAS,
        ROW_WRITE
    } t_row_kind;

    // One row of the directed table. For a measurement row, value carries the
    // measurement in its low 16 bits and reps says how often it is sent. A
    // typed expectation applies to the last repetition only.
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] value;
        int                   reps;
        bit                   typed;
        logic signed [DRIVE_W-1:0] drive;
        logic                 saturated;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    wpid_meas_if   meas_ch();
    wpid_cfg_if    cfg_ch();
    wpid_result_if res_ch();

    windowed_pid_controller_unit #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meas  (meas_ch),
        .i_cfg   (cfg_ch),
        .o_result(res_ch)
    );

    // Predictor state: its own copy of the registers and of the error window.
    logic signed [SETPT_W-1:0] setpt;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic signed [ERR_W-1:0]   err_hist[WINDOW];
    logic signed [SUM_W-1:0]   win_sum;
    int unsigned               newest_slot;

    // Results still owed by the block, oldest first.
    t_drive_word pending_drives[$];

    int  fail_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;

    // The directed table. Typed expectations only appear where the value is
    // obvious: zero error after reset, all gains zero, and clipping at either
    // end once the window holds mostly full-scale errors.
    t_stim_row stim_table[NUM_ROWS] = '{
        '{ROW_MEAS,  8'd0,                   20'h00064, 1, 1'b1, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h07FFF, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h08000, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h00000, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_WRITE, CFG_IDX_UNUSED,         20'hFFFFF, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h00064, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_WRITE, wpid_pkg::CFG_GAIN_P,   20'h00000, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_WRITE, wpid_pkg::CFG_GAIN_I,   20'h00000, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_WRITE, wpid_pkg::CFG_GAIN_D,   20'h00000, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h08000, 1, 1'b1, 32'sd0, 1'b0},
        '{ROW_WRITE, wpid_pkg::CFG_SETPOINT, 20'hF7FFF, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_WRITE, wpid_pkg::CFG_GAIN_P,   GAIN_FULL, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_WRITE, wpid_pkg::CFG_GAIN_I,   GAIN_FULL, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_WRITE, wpid_pkg::CFG_GAIN_D,   GAIN_FULL, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h08000, 8, 1'b1, 32'sh7FFFFFFF, 1'b1},
        '{ROW_WRITE, wpid_pkg::CFG_SETPOINT, 20'h08000, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h07FFF, 9, 1'b1, 32'sh80000000, 1'b1},
        '{ROW_WRITE, wpid_pkg::CFG_SETPOINT, 20'h00064, 1, 1'b0, 32'sd0, 1'b0},
        '{ROW_MEAS,  8'd0,                   20'h01234, 1, 1'b0, 32'sd0, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void reset_model();
        setpt = wpid_pkg::SETPT_RST;
        kp    = wpid_pkg::GAIN_P_RST;
        ki    = wpid_pkg::GAIN_I_RST;
        kd    = wpid_pkg::GAIN_D_RST;
        foreach (err_hist[k]) err_hist[k] = '0;
        win_sum     = '0;
        newest_slot = 0;
    endfunction

    // A register write keeps only the bits the register holds; the setpoint
    // takes the low 16 bits as a signed value. Indexes past the list do nothing.
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            wpid_pkg::CFG_SETPOINT: setpt = data[SETPT_W-1:0];
            wpid_pkg::CFG_GAIN_P:   kp = data[GAIN_W-1:0];
            wpid_pkg::CFG_GAIN_I:   ki = data[GAIN_W-1:0];
            wpid_pkg::CFG_GAIN_D:   kd = data[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    // Shifts one error into the window and returns the drive word it causes.
    // Before the window has filled, the missing entries are zero, so the very
    // first error after reset sees a previous error of zero.
    function automatic t_drive_word compute_drive(input logic signed [MEAS_W-1:0] m);
        logic signed [ERR_W-1:0] err_now;
        logic signed [ERR_W-1:0] err_last;
        int unsigned             slot;
        longint                  acc;
        longint                  scaled;
        t_drive_word             w;
        err_now  = setpt - m;
        err_last = err_hist[newest_slot];
        slot     = (newest_slot + 1) % WINDOW;
        // The slot after the newest holds the oldest error, which drops out.
        win_sum  = win_sum - err_hist[slot] + err_now;
        err_hist[slot] = err_now;
        newest_slot    = slot;
        acc = longint'(kp) * longint'(err_now)
            + longint'(ki) * longint'(win_sum)
            + longint'(kd) * (longint'(err_now) - longint'(err_last));
        // An arithmetic shift of a signed value rounds toward minus infinity.
        scaled = acc >>> FRAC_W;
        w.saturated = 1'b0;
        if (scaled > DRIVE_MAX) begin
            scaled      = DRIVE_MAX;
            w.saturated = 1'b1;
        end else if (scaled < DRIVE_MIN) begin
            scaled      = DRIVE_MIN;
            w.saturated = 1'b1;
        end
        w.drive = scaled[DRIVE_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one measurement word, with a random gap in front of it when the
    // sender is idling. Valid stays high after acceptance so that back-to-back
    // words need no second assignment in the same step; whoever idles next
    // lowers it.
    task automatic send_measurement(input logic signed [MEAS_W-1:0] m,
                                    input bit typed, input t_drive_word typed_word);
        t_drive_word w;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            meas_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        meas_ch.valid       <= 1'b1;
        meas_ch.measurement <= m;
        do @(posedge i_clk); while (!meas_ch.ready);
        w = compute_drive(m);
        pending_drives.push_back(typed ? typed_word : w);
    endtask

    // Registers may change only while the block is empty. Valid on the
    // measurement channel drops first, then every owed word must have come
    // back, and then the pipeline gets its latency to settle.
    task automatic wait_idle();
        meas_ch.valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 1) @(posedge i_clk);
    endtask

    // Writes one register word. Valid is left high; the caller lowers it once
    // the batch of writes is done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, data);
    endtask

    // Gains lean toward the corners: zero, full scale and very small values
    // all show up often, the rest are spread over the whole range.
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return GAIN_FULL;
            2:       return GAIN_W'($urandom_range(1023));
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    // Measurements mix full-range noise with values near the setpoint, the
    // two extremes, steady runs and slow ramps, so that the window sum builds
    // up and the derivative term sees both large and small steps.
    function automatic logic signed [MEAS_W-1:0] next_measurement(
            input logic signed [MEAS_W-1:0] last);
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return setpt + MEAS_W'($urandom_range(64)) - 16'sd32;
            3:       return last;
            4:       return last + MEAS_W'($urandom_range(7));
            default: return MEAS_W'($urandom());
        endcase
    endfunction

    // Programs a new setting and idling mode for one random phase. The first
    // two phases pin the registers to fixed values at or near their extremes.
    task automatic program_phase(input int phase);
        wait_idle();
        send_idle_pct  = SEND_IDLE_PCT[phase % 4];
        recv_stall_pct = RECV_STALL_PCT[phase % 4];
        if (phase == 0) begin
            write_reg(wpid_pkg::CFG_SETPOINT, 20'h07FFF);
            write_reg(wpid_pkg::CFG_GAIN_P, GAIN_FULL);
            write_reg(wpid_pkg::CFG_GAIN_I, GAIN_FULL);
            write_reg(wpid_pkg::CFG_GAIN_D, GAIN_FULL);
        end else if (phase == 1) begin
            write_reg(wpid_pkg::CFG_SETPOINT, 20'h08000);
            write_reg(wpid_pkg::CFG_GAIN_P, 20'd1);
            write_reg(wpid_pkg::CFG_GAIN_I, '0);
            write_reg(wpid_pkg::CFG_GAIN_D, GAIN_FULL);
        end else begin
            // The setpoint word carries random upper bits that must be dropped.
            write_reg(wpid_pkg::CFG_SETPOINT, CFG_DAT_W'($urandom()));
            write_reg(wpid_pkg::CFG_GAIN_P, pick_gain());
            write_reg(wpid_pkg::CFG_GAIN_I, pick_gain());
            write_reg(wpid_pkg::CFG_GAIN_D, pick_gain());
            if ($urandom_range(1))
                write_reg(CFG_IDX_W'($urandom_range(255, CFG_IDX_PAST_END)),
                          CFG_DAT_W'($urandom()));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Clock and time limit
    // ------------------------------------------------------------------------

    initial i_clk = 1'b0;
    always #5ns i_clk = ~i_clk;

    // The time limit lies well beyond what a correct run needs.
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, one long hold-off on request,
    // and a field by field check of every accepted result word.
    // ------------------------------------------------------------------------

    initial begin
        int          hold_left;
        t_drive_word want;
        t_drive_word got;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.drive     = res_ch.drive;
                got.saturated = res_ch.saturated;
                if (pending_drives.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%t: unexpected result word drive=%0d saturated=%0b",
                                 $realtime, got.drive, got.saturated);
                end else begin
                    want = pending_drives.pop_front();
                    if (got.drive !== want.drive || got.saturated !== want.saturated) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%t: mismatch drive exp=%0d got=%0d, saturated exp=%0b got=%0b",
                                     $realtime, want.drive, got.drive,
                                     want.saturated, got.saturated);
                    end
                end
            end
            // The long hold-off lets the block fill up while the sender keeps
            // offering words, so its input must stall.
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain.
    // ------------------------------------------------------------------------

    initial begin
        t_drive_word             typed_word;
        logic signed [MEAS_W-1:0] m;
        bit                      in_writes;
        int                      drain_cycles;

        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        in_writes      = 1'b0;
        reset_model();

        // Every input is known from the very start of the run.
        i_rst_n             <= 1'b0;
        meas_ch.valid       <= 1'b0;
        meas_ch.measurement <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A run of writes is entered through wait_idle so the
        // block is empty, and left by lowering the write valid.
        foreach (stim_table[r]) begin
            if (stim_table[r].kind == ROW_WRITE) begin
                if (!in_writes) wait_idle();
                in_writes = 1'b1;
                write_reg(stim_table[r].idx, stim_table[r].value);
            end else begin
                if (in_writes) cfg_ch.valid <= 1'b0;
                in_writes = 1'b0;
                typed_word.drive     = stim_table[r].drive;
                typed_word.saturated = stim_table[r].saturated;
                for (int n = 0; n < stim_table[r].reps; n++)
                    send_measurement(stim_table[r].value[MEAS_W-1:0],
                                     stim_table[r].typed && n == stim_table[r].reps - 1,
                                     typed_word);
            end
        end

        // Random part. Each phase picks its own registers and idling mode;
        // the first one, without idling, also carries the long hold-off.
        m = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            program_phase(p);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == 40) hold_request = 1'b1;
                m = next_measurement(m);
                send_measurement(m, 1'b0, typed_word);
            end
        end

        // Drain: wait for every owed word, then give the pipeline time to
        // show anything extra.
        meas_ch.valid <= 1'b0;
        drain_cycles = 0;
        while (pending_drives.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        fail_count += pending_drives.size();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/wpid_pkg.sv
design/wpid_ifs.sv
design/wpid_mac.sv
design/windowed_pid_controller_unit.sv
design/wpid_checker.sv
dv/windowed_pid_controller_unit_test.sv
